[hdl/average_of_averages_filter_core_defines.svh]
// Assertion macros shared by the filter modules.
// Each macro expects aclk and aresetn to be visible where it is used.
`ifndef AVERAGE_OF_AVERAGES_FILTER_CORE_DEFINES_SVH
`define AVERAGE_OF_AVERAGES_FILTER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked only while the block is out of reset.
`define AOAF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Checked at every edge, reset included.
`define AOAF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define AOAF_ASSERT(lbl, prop, msg)
`define AOAF_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[hdl/aoaf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package aoaf_pkg;

    localparam int ADC_W      = 12;
    localparam int TEMP_W     = 19;
    localparam int WINDOW_DEPTH_DEFAULT = 20;

    // raw_temp = sample * 715 * 256 / 2096 = sample * 11440 / 131 (common factor 16).
    // It is taken as sample * ceil(11440 * 2^20 / 131) >> 20, exact for every 12-bit sample.
    localparam int RAW_RECIP_W = 27;
    localparam int RAW_PROD_W  = ADC_W + RAW_RECIP_W;
    localparam int RAW_SHIFT   = 20;
    localparam logic [RAW_RECIP_W-1:0] RAW_RECIP = 27'd91570302;

    // Shared divider: numerator covers the temperature sums of the largest window.
    localparam int DIV_NUM_W  = 26;
    localparam int DIV_DEN_W  = 8;
    localparam int DIV_CNT_W  = $clog2(DIV_NUM_W);

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIV_NUM_W-1:0] quo;
    } div_rsp_t;

endpackage
`default_nettype wire

[hdl/aoaf_ring.sv]
`timescale 1ns / 1ps
`default_nettype none
module aoaf_ring
    import aoaf_pkg::*;
#(
    parameter int DEPTH  = WINDOW_DEPTH_DEFAULT,
    parameter int SLOT_W = 5
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [SLOT_W-1:0] wr_addr,
    input  wire logic [ADC_W-1:0]  wr_adc,
    input  wire logic [TEMP_W-1:0] wr_temp,
    input  wire logic              rd_en,
    input  wire logic [SLOT_W-1:0] rd_addr,
    output logic      [ADC_W-1:0]  rd_adc,
    output logic      [TEMP_W-1:0] rd_temp
);

    logic [ADC_W-1:0]  adc_mem  [DEPTH];
    logic [TEMP_W-1:0] temp_mem [DEPTH];
    logic [ADC_W-1:0]  rd_adc_reg;
    logic [TEMP_W-1:0] rd_temp_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            adc_mem[wr_addr]  <= wr_adc;
            temp_mem[wr_addr] <= wr_temp;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_adc_reg  <= adc_mem[rd_addr];
            rd_temp_reg <= temp_mem[rd_addr];
        end
    end

    assign rd_adc  = rd_adc_reg;
    assign rd_temp = rd_temp_reg;

endmodule
`default_nettype wire

[hdl/aoaf_divider.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "average_of_averages_filter_core_defines.svh"
module aoaf_divider
    import aoaf_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    // Restoring division, one quotient bit per cycle, numerator shifted out MSB first.
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;

    logic [DIV_DEN_W:0]   shifted;
    logic [DIV_DEN_W:0]   diff;
    logic                 fits;
    logic                 last_step;

    assign shifted   = {rem_reg, quo_reg[DIV_NUM_W-1]};
    assign diff      = shifted - {1'b0, den_reg};
    assign fits      = shifted >= {1'b0, den_reg};
    assign last_step = cnt_reg == DIV_CNT_W'(DIV_NUM_W - 1);

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.num;
            den_next  = req.den;
        end else if (busy_reg) begin
            rem_next = fits ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
            quo_next = {quo_reg[DIV_NUM_W-2:0], fits};
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (last_step) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

    `AOAF_ASSERT(a_start_when_free, req.start |-> !busy_reg, "divider started while busy")
    `AOAF_ASSERT(a_done_after_run, done_reg |-> !busy_reg && $past(busy_reg), "stray done")
    `AOAF_ASSERT(a_busy_from_start, $rose(busy_reg) |-> $past(req.start), "busy without start")

endmodule
`default_nettype wire

[hdl/average_of_averages_filter_core.sv]
// A request is followed by the history walk, then the shared 26-step divider runs twice
// (ADC mean, temperature mean), and the output register is loaded last.
// A new request is taken only in idle, once the last result has been loaded into the output
// register; a waiting result does not block the next request, but that request's own result
// is held in the output state until the waiting result is taken.
// Reset (aresetn, synchronous, active low) clears the sequencer, history walk, write slot, fill count and m_valid.
`timescale 1ns / 1ps
`default_nettype none
`include "average_of_averages_filter_core_defines.svh"
module average_of_averages_filter_core
    import aoaf_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEFAULT
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [ADC_W-1:0]  s_sample,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic      [ADC_W-1:0]  m_filtered_adc,
    output logic      [TEMP_W-1:0] m_raw_temp,
    output logic      [TEMP_W-1:0] m_filtered_temp
);

    localparam int SLOT_W     = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W      = $clog2(WINDOW_DEPTH + 1);
    localparam int ADC_ACC_W  = ADC_W + CNT_W;
    localparam int TEMP_ACC_W = TEMP_W + CNT_W;

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_SUM      = 5'b00010,
        ST_DIV_ADC  = 5'b00100,
        ST_DIV_TEMP = 5'b01000,
        ST_OUT      = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [ADC_W-1:0]      sample_reg, sample_next;
    logic [TEMP_W-1:0]     raw_reg, raw_next;
    logic [ADC_W-1:0]      adc_res_reg, adc_res_next;
    logic [TEMP_W-1:0]     temp_res_reg, temp_res_next;
    logic [SLOT_W-1:0]     write_slot_reg, write_slot_next;
    logic [CNT_W-1:0]      fill_count_reg, fill_count_next;

    logic                  walk_active_reg, walk_active_next;
    logic [CNT_W-1:0]      walk_idx_reg, walk_idx_next;
    logic                  rd_vld_reg;
    logic [ADC_ACC_W-1:0]  adc_acc_reg, adc_acc_next;
    logic [TEMP_ACC_W-1:0] temp_acc_reg, temp_acc_next;

    logic                  m_valid_reg, m_valid_next;
    logic [ADC_W-1:0]      m_adc_reg, m_adc_next;
    logic [TEMP_W-1:0]     m_raw_reg, m_raw_next;
    logic [TEMP_W-1:0]     m_temp_reg, m_temp_next;

    logic                  accept;
    logic                  rd_en;
    logic                  walk_done;
    logic                  wr_en;
    logic [ADC_W-1:0]      rd_adc;
    logic [TEMP_W-1:0]     rd_temp;
    logic [DIV_DEN_W-1:0]  mean_den;
    logic [RAW_PROD_W-1:0] raw_prod;
    logic [CNT_W-1:0]      slot_count;
    div_req_t              div_req;
    div_rsp_t              div_rsp;

    assign s_ready    = state_reg == ST_IDLE;
    assign accept     = s_valid && s_ready;
    assign rd_en      = walk_active_reg && (walk_idx_reg != fill_count_reg);
    assign walk_done  = !walk_active_reg && !rd_vld_reg;
    assign wr_en      = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
    assign mean_den   = DIV_DEN_W'(fill_count_reg) + DIV_DEN_W'(1);
    assign raw_prod   = RAW_PROD_W'(s_sample) * RAW_PROD_W'(RAW_RECIP);
    assign slot_count = CNT_W'(write_slot_reg);

    aoaf_ring #(
        .DEPTH  (WINDOW_DEPTH),
        .SLOT_W (SLOT_W)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (write_slot_reg),
        .wr_adc  (adc_res_reg),
        .wr_temp (temp_res_reg),
        .rd_en   (rd_en),
        .rd_addr (walk_idx_reg[SLOT_W-1:0]),
        .rd_adc  (rd_adc),
        .rd_temp (rd_temp)
    );

    aoaf_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // History walk: reads entries 0 .. fill_count-1 and sums them, one per cycle.
    always_comb begin
        walk_active_next = walk_active_reg;
        walk_idx_next    = walk_idx_reg;
        adc_acc_next     = adc_acc_reg;
        temp_acc_next    = temp_acc_reg;
        if (accept) begin
            walk_active_next = 1'b1;
            walk_idx_next    = '0;
            adc_acc_next     = '0;
            temp_acc_next    = '0;
        end else begin
            if (walk_active_reg) begin
                if (rd_en) begin
                    walk_idx_next = walk_idx_reg + CNT_W'(1);
                end else begin
                    walk_active_next = 1'b0;
                end
            end
            if (rd_vld_reg) begin
                adc_acc_next  = adc_acc_reg + ADC_ACC_W'(rd_adc);
                temp_acc_next = temp_acc_reg + TEMP_ACC_W'(rd_temp);
            end
        end
    end

    always_comb begin
        state_next      = state_reg;
        sample_next     = sample_reg;
        raw_next        = raw_reg;
        adc_res_next    = adc_res_reg;
        temp_res_next   = temp_res_reg;
        write_slot_next = write_slot_reg;
        fill_count_next = fill_count_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_adc_next      = m_adc_reg;
        m_raw_next      = m_raw_reg;
        m_temp_next     = m_temp_reg;
        div_req.start   = 1'b0;
        div_req.num     = '0;
        div_req.den     = mean_den;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    sample_next = s_sample;
                    raw_next    = raw_prod[RAW_SHIFT +: TEMP_W];
                    state_next  = ST_SUM;
                end
            end
            ST_SUM: begin
                div_req.num = DIV_NUM_W'(adc_acc_reg) + DIV_NUM_W'(sample_reg);
                div_req.den = mean_den;
                if (walk_done) begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIV_ADC;
                end
            end
            ST_DIV_ADC: begin
                div_req.num = DIV_NUM_W'(temp_acc_reg) + DIV_NUM_W'(raw_reg);
                div_req.den = mean_den;
                if (div_rsp.done) begin
                    adc_res_next  = div_rsp.quo[ADC_W-1:0];
                    div_req.start = 1'b1;
                    state_next    = ST_DIV_TEMP;
                end
            end
            ST_DIV_TEMP: begin
                if (div_rsp.done) begin
                    temp_res_next = div_rsp.quo[TEMP_W-1:0];
                    state_next    = ST_OUT;
                end
            end
            ST_OUT: begin
                if (wr_en) begin
                    m_valid_next = 1'b1;
                    m_adc_next   = adc_res_reg;
                    m_raw_next   = raw_reg;
                    m_temp_next  = temp_res_reg;
                    if (write_slot_reg == SLOT_W'(WINDOW_DEPTH - 1)) begin
                        write_slot_next = '0;
                    end else begin
                        write_slot_next = write_slot_reg + SLOT_W'(1);
                    end
                    if (fill_count_reg < CNT_W'(WINDOW_DEPTH)) begin
                        fill_count_next = fill_count_reg + CNT_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            write_slot_reg  <= '0;
            fill_count_reg  <= '0;
            walk_active_reg <= 1'b0;
            rd_vld_reg      <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            write_slot_reg  <= write_slot_next;
            fill_count_reg  <= fill_count_next;
            walk_active_reg <= walk_active_next;
            rd_vld_reg      <= rd_en;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg   <= sample_next;
        raw_reg      <= raw_next;
        adc_res_reg  <= adc_res_next;
        temp_res_reg <= temp_res_next;
        walk_idx_reg <= walk_idx_next;
        adc_acc_reg  <= adc_acc_next;
        temp_acc_reg <= temp_acc_next;
        m_adc_reg    <= m_adc_next;
        m_raw_reg    <= m_raw_next;
        m_temp_reg   <= m_temp_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_filtered_adc  = m_adc_reg;
    assign m_raw_temp      = m_raw_reg;
    assign m_filtered_temp = m_temp_reg;

    `AOAF_ASSERT(a_fill_bounded, fill_count_reg <= CNT_W'(WINDOW_DEPTH), "fill count overflow")
    `AOAF_ASSERT(a_slot_tracks_fill, (fill_count_reg != CNT_W'(WINDOW_DEPTH)) |-> (slot_count == fill_count_reg), "slot and fill disagree")
    `AOAF_ASSERT(a_no_write_during_walk, wr_en |-> walk_done, "ring written during walk")
    `AOAF_ASSERT(a_div_free_when_idle, s_ready |-> !div_rsp.busy, "divider busy while idle")
    `AOAF_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> s_ready && !m_valid, "not idle after reset")

endmodule
`default_nettype wire
